// File: sv/csm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_pkg
// Shared widths, types and constants of the cosine similarity match core.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int MAX_LEN    = 512;
    localparam int CNT_W      = $clog2(MAX_LEN + 1);
    localparam int NORM_W     = 31 + $clog2(MAX_LEN);
    localparam int DOT_W      = NORM_W + 1;
    localparam int HALF_W     = (NORM_W + 1) / 2;
    localparam int PROD_W     = 2 * NORM_W;
    localparam int PQ_W       = PROD_W + 16;
    localparam int WIDE_W     = PROD_W + 32;
    localparam int FRAC_SHIFT = 30;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic signed [15:0] THR_RESET = 16'sd16384;

    typedef logic signed [15:0] t_elem;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       n1;
        logic [NORM_W-1:0]       n2;
        logic                    too_long;
    } t_snap;

    typedef struct packed {
        logic signed [15:0] similarity;
        logic               same_person;
        logic               zero_norm;
        logic               too_long;
    } t_result;

endpackage
`default_nettype wire

// File: sv/cosine_similarity_match_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_similarity_match_core
// Streaming cosine similarity of two Q4.12 vectors with a match decision.
// ----------------------------------------------------------------------------
// Takes one element pair per clock while o_full is low. Pairs beyond MAX_LEN
// are dropped and flag too_long. The ratio unit loads each snapshot; for a
// vector of zero norm it goes straight to the finish state, for others it
// builds the products in multiply steps and runs a candidate and a compare
// state per quotient bit first. The finish state forms the result word
// (similarity in Q1.15, same_person, zero_norm, too_long); no new snapshot is
// taken until it is formed, so short vectors are limited by it. A four-deep
// snapshot queue lets pairs keep streaming while the ratio unit and result wait.
module cosine_similarity_match_core (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_full,
    input  wire signed [15:0] i_first_elem,
    input  wire signed [15:0] i_second_elem,
    input  wire               i_last_elem,
    output logic              o_empty,
    input  wire               i_pop,
    output logic signed [15:0] o_similarity,
    output logic              o_same_person,
    output logic              o_zero_norm,
    output logic              o_too_long,
    input  wire               i_cfg_wr_en,
    input  wire signed [15:0] i_cfg_wr_data
);
    import csm_pkg::*;

    logic signed [15:0] r_thr;
    logic               snap_valid;
    t_snap              snap;
    logic               q_empty;
    t_snap              q_data;
    logic               take;
    t_result            result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_wr_en) begin
            r_thr <= i_cfg_wr_data;
        end
    end

    csm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .i_first_elem  (i_first_elem),
        .i_second_elem (i_second_elem),
        .i_last_elem   (i_last_elem),
        .i_credit_ret  (take),
        .o_full        (o_full),
        .o_snap_valid  (snap_valid),
        .o_snap        (snap)
    );

    csm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (snap_valid),
        .i_data  (snap),
        .i_pop   (take),
        .o_empty (q_empty),
        .o_data  (q_data)
    );

    csm_ratio u_ratio (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (~q_empty),
        .i_snap   (q_data),
        .i_thr    (r_thr),
        .i_pop    (i_pop),
        .o_take   (take),
        .o_empty  (o_empty),
        .o_result (result)
    );

    assign o_similarity  = result.similarity;
    assign o_same_person = result.same_person;
    assign o_zero_norm   = result.zero_norm;
    assign o_too_long    = result.too_long;

endmodule
`default_nettype wire

// File: sv/csm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_front
// Accepts element pairs, accumulates dot product and squared norms, hands a
// snapshot of the sums to the snapshot queue on the last pair.
// ----------------------------------------------------------------------------
module csm_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  csm_pkg::t_elem       i_first_elem,
    input  csm_pkg::t_elem       i_second_elem,
    input  wire                  i_last_elem,
    input  wire                  i_credit_ret,
    output logic                 o_full,
    output logic                 o_snap_valid,
    output csm_pkg::t_snap       o_snap
);
    import csm_pkg::*;

    localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(MAX_LEN);
    localparam logic [QCNT_W-1:0] QFULL    = QCNT_W'(QDEPTH);

    logic [QCNT_W-1:0]        r_credit;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ovf;
    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic                     r_s1_ovf;
    logic signed [31:0]       r_p_ab;
    logic [30:0]              r_p_aa;
    logic [30:0]              r_p_bb;
    logic signed [DOT_W-1:0]  r_dot;
    logic [NORM_W-1:0]        r_n1;
    logic [NORM_W-1:0]        r_n2;
    logic                     r_snap_valid;
    t_snap                    r_snap;

    logic                     accept;
    logic                     drop;
    logic signed [31:0]       p_ab;
    logic signed [31:0]       p_aa;
    logic signed [31:0]       p_bb;
    logic signed [DOT_W-1:0]  sum_dot;
    logic [NORM_W-1:0]        sum_n1;
    logic [NORM_W-1:0]        sum_n2;

    assign o_full   = (r_credit == QFULL);
    assign accept   = i_push & ~o_full;
    assign drop     = (r_cnt == MAX_CNT);
    assign p_ab     = i_first_elem * i_second_elem;
    assign p_aa     = i_first_elem * i_first_elem;
    assign p_bb     = i_second_elem * i_second_elem;
    assign sum_dot  = r_dot + DOT_W'(r_p_ab);
    assign sum_n1   = r_n1 + NORM_W'(r_p_aa);
    assign sum_n2   = r_n2 + NORM_W'(r_p_bb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit     <= '0;
            r_cnt        <= '0;
            r_ovf        <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s1_last    <= 1'b0;
            r_dot        <= '0;
            r_n1         <= '0;
            r_n2         <= '0;
            r_snap_valid <= 1'b0;
        end else begin
            r_credit <= r_credit + QCNT_W'(accept & i_last_elem) - QCNT_W'(i_credit_ret);
            r_s1_valid <= accept;
            r_s1_last  <= accept & i_last_elem;
            if (accept) begin
                if (i_last_elem) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                end else if (!drop) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            r_snap_valid <= r_s1_valid & r_s1_last;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_dot <= '0;
                    r_n1  <= '0;
                    r_n2  <= '0;
                end else begin
                    r_dot <= sum_dot;
                    r_n1  <= sum_n1;
                    r_n2  <= sum_n2;
                end
            end
        end
        r_s1_ovf <= r_ovf | drop;
        r_p_ab   <= drop ? 32'sd0 : p_ab;
        r_p_aa   <= drop ? 31'd0 : p_aa[30:0];
        r_p_bb   <= drop ? 31'd0 : p_bb[30:0];
        if (r_s1_valid && r_s1_last) begin
            r_snap.dot      <= sum_dot;
            r_snap.n1       <= sum_n1;
            r_snap.n2       <= sum_n2;
            r_snap.too_long <= r_s1_ovf;
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_snap       = r_snap;

endmodule
`default_nettype wire

// File: sv/csm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_queue
// Short queue of vector snapshots between the accumulator and ratio unit.
// ----------------------------------------------------------------------------
module csm_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  csm_pkg::t_snap  i_data,
    input  wire             i_pop,
    output logic            o_empty,
    output csm_pkg::t_snap  o_data
);
    import csm_pkg::*;

    t_snap               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

endmodule
`default_nettype wire

// File: sv/csm_ratio.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csm_ratio
// Computes floor(32768*|dot|/sqrt(n1*n2)) bit by bit, signs and saturates it,
// compares against the threshold and holds the result word.
// ----------------------------------------------------------------------------
module csm_ratio (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    input  csm_pkg::t_snap      i_snap,
    input  wire signed [15:0]   i_thr,
    input  wire                 i_pop,
    output logic                o_take,
    output logic                o_empty,
    output csm_pkg::t_result    o_result
);
    import csm_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_CAND, S_CMP, S_FIN} t_state;

    t_state               r_state;
    logic [1:0]           r_step;
    logic [3:0]           r_bit;
    logic [NORM_W-1:0]    r_n1;
    logic [NORM_W-1:0]    r_n2;
    logic [NORM_W-1:0]    r_mag;
    logic                 r_neg;
    logic                 r_zero;
    logic                 r_ovf;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    r_magsq;
    logic [WIDE_W-1:0]    r_t;
    logic [PQ_W-1:0]      r_pq;
    logic [WIDE_W-1:0]    r_cand;
    logic [15:0]          r_q;
    logic                 r_res_valid;
    t_result              r_result;

    logic [HALF_W-1:0]    a_part;
    logic [HALF_W-1:0]    b_part;
    logic [HALF_W-1:0]    m_part_a;
    logic [HALF_W-1:0]    m_part_b;
    logic [2*HALF_W-1:0]  pp_prod;
    logic [2*HALF_W-1:0]  pp_mag;
    logic [PROD_W-1:0]    pp_prod_sh;
    logic [PROD_W-1:0]    pp_mag_sh;
    logic [WIDE_W-1:0]    cand;
    logic [WIDE_W-1:0]    rhs;
    logic signed [15:0]   sim;
    logic [NORM_W-1:0]    snap_mag;

    assign snap_mag = i_snap.dot[DOT_W-1] ? NORM_W'(-i_snap.dot) : NORM_W'(i_snap.dot);

    assign a_part   = r_step[1] ? HALF_W'(r_n1 >> HALF_W)  : r_n1[HALF_W-1:0];
    assign b_part   = r_step[0] ? HALF_W'(r_n2 >> HALF_W)  : r_n2[HALF_W-1:0];
    assign m_part_a = r_step[1] ? HALF_W'(r_mag >> HALF_W) : r_mag[HALF_W-1:0];
    assign m_part_b = r_step[0] ? HALF_W'(r_mag >> HALF_W) : r_mag[HALF_W-1:0];
    assign pp_prod  = a_part * b_part;
    assign pp_mag   = m_part_a * m_part_b;

    always_comb begin
        case (r_step)
            2'd0: begin
                pp_prod_sh = PROD_W'(pp_prod);
                pp_mag_sh  = PROD_W'(pp_mag);
            end
            2'd3: begin
                pp_prod_sh = PROD_W'(pp_prod) << (2 * HALF_W);
                pp_mag_sh  = PROD_W'(pp_mag) << (2 * HALF_W);
            end
            default: begin
                pp_prod_sh = PROD_W'(pp_prod) << HALF_W;
                pp_mag_sh  = PROD_W'(pp_mag) << HALF_W;
            end
        endcase
    end

    assign cand = r_t + (WIDE_W'(r_pq) << ({1'b0, r_bit} + 5'd1))
                + (WIDE_W'(r_prod) << {r_bit, 1'b0});
    assign rhs  = WIDE_W'(r_magsq) << FRAC_SHIFT;

    always_comb begin
        if (r_zero) begin
            sim = 16'sd0;
        end else if (r_neg) begin
            sim = (r_q > 16'd32768) ? -16'sd32768 : $signed(16'(17'd0 - {1'b0, r_q}));
        end else begin
            sim = (r_q > 16'd32767) ? 16'sd32767 : $signed(r_q);
        end
    end

    assign o_take = (r_state == S_IDLE) & i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (i_pop && (r_state != S_FIN)) r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_n1    <= i_snap.n1;
                        r_n2    <= i_snap.n2;
                        r_mag   <= snap_mag;
                        r_neg   <= i_snap.dot[DOT_W-1];
                        r_ovf   <= i_snap.too_long;
                        r_zero  <= (i_snap.n1 == '0) | (i_snap.n2 == '0);
                        r_prod  <= '0;
                        r_magsq <= '0;
                        r_step  <= 2'd0;
                        r_q     <= '0;
                        r_state <= ((i_snap.n1 == '0) | (i_snap.n2 == '0)) ? S_FIN : S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= r_prod + pp_prod_sh;
                    r_magsq <= r_magsq + pp_mag_sh;
                    r_step  <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_bit   <= 4'd15;
                        r_t     <= '0;
                        r_pq    <= '0;
                        r_state <= S_CAND;
                    end
                end
                S_CAND: begin
                    r_cand  <= cand;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (r_cand <= rhs) begin
                        r_t        <= r_cand;
                        r_pq       <= r_pq + (PQ_W'(r_prod) << r_bit);
                        r_q[r_bit] <= 1'b1;
                    end
                    if (r_bit == 4'd0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_bit   <= r_bit - 4'd1;
                        r_state <= S_CAND;
                    end
                end
                S_FIN: begin
                    if (!r_res_valid || i_pop) begin
                        r_result.similarity  <= sim;
                        r_result.same_person <= (sim >= i_thr);
                        r_result.zero_norm   <= r_zero;
                        r_result.too_long    <= r_ovf;
                        r_res_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty  = ~r_res_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire
